// ----- rtl/core/dnsq_pkg.sv -----
// ============================================================================
// dnsq_pkg: shared types and constants for the DNS question parser
// Field widths, result codes and the byte values the parser looks for.
// ============================================================================
package dnsq_pkg;

    // Field and state widths.
    localparam int BYTE_W     = 8;
    localparam int ID_W       = 16;
    localparam int POS_W      = 11;
    localparam int NAME_LEN_W = 10;
    localparam int LABEL_W    = 6;

    // Default limit on the dotted name length.
    localparam int MAX_NAME_DEFAULT = 256;

    // Header layout.
    localparam logic [POS_W-1:0] POS_TXID_HI  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TXID_LO  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_QDCNT_HI = POS_W'(4);
    localparam logic [POS_W-1:0] POS_QDCNT_LO = POS_W'(5);
    localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(11);
    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

    // Byte values.
    localparam logic [BYTE_W-1:0] LABEL_FLAG_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_DOT        = 8'h2E;

    // Result word kinds.
    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

endpackage

// ----- rtl/core/dnsq_byte_if.sv -----
// ============================================================================
// dnsq_byte_if: packet byte channel
// Valid/ready channel that carries one packet byte and its last-byte mark.
// ============================================================================
interface dnsq_byte_if
    import dnsq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/dnsq_result_if.sv -----
// ============================================================================
// dnsq_result_if: parser result channel
// Valid/ready channel that carries one name character, done or malformed word.
// ============================================================================
interface dnsq_result_if
    import dnsq_pkg::*;
();
    logic                  valid;
    logic                  ready;
    kind_t                 kind;
    logic [BYTE_W-1:0]     name_char;
    logic [ID_W-1:0]       txid;
    logic [ID_W-1:0]       query_type;
    logic [ID_W-1:0]       query_class;
    logic [POS_W-1:0]      end_offset;
    logic [NAME_LEN_W-1:0] name_length;

    modport source (
        output valid, output kind, output name_char, output txid, output query_type,
        output query_class, output end_offset, output name_length, input ready
    );
    modport sink (
        input valid, input kind, input name_char, input txid, input query_type,
        input query_class, input end_offset, input name_length, output ready
    );
endinterface

// ----- rtl/core/dns_question_parser_top.sv -----
// ============================================================================
// dns_question_parser_top: streaming DNS question section parser
// Walks the header and first question of a query packet, one byte per word.
// ============================================================================
// The parser takes one packet byte per cycle and gives at most one result
// word per byte: a lowercased name character (or a dot between labels), a
// done word with the transaction id, qtype, qclass, question end offset and
// name length, or a malformed word. Each byte is decoded in the cycle it is
// accepted and its result lands in a single output register, so a new byte
// is taken every cycle as long as that register is empty or is being read in
// the same cycle; the only stall comes from back pressure on the result
// channel. After done or malformed the remaining bytes are dropped until the
// last-byte mark, which readies the parser for the next packet.
module dns_question_parser_top
    import dnsq_pkg::*;
#(
    parameter int MAX_NAME = MAX_NAME_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    dnsq_byte_if.sink     byte_in,
    dnsq_result_if.source result_out
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_CLASS_HI,
        PH_CLASS_LO,
        PH_IGNORE
    } phase_t;

    localparam logic [POS_W-1:0] NAME_LIMIT = POS_W'(MAX_NAME);

    phase_t                phase_reg, phase_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [LABEL_W-1:0]    label_reg, label_next;
    logic [NAME_LEN_W-1:0] chars_reg, chars_next;
    logic [ID_W-1:0]       txid_reg, txid_next;
    logic                  cnt_hi_reg, cnt_hi_next;
    logic [ID_W-1:0]       type_reg, type_next;
    logic [BYTE_W-1:0]     class_hi_reg, class_hi_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    kind_t                 kind_reg, kind_next;
    logic [BYTE_W-1:0]     char_reg, char_next;
    logic [ID_W-1:0]       otxid_reg, otxid_next;
    logic [ID_W-1:0]       otype_reg, otype_next;
    logic [ID_W-1:0]       oclass_reg, oclass_next;
    logic [POS_W-1:0]      oend_reg, oend_next;
    logic [NAME_LEN_W-1:0] olen_reg, olen_next;

    logic              accept;
    logic              res_load;
    logic              bad;
    logic              clear;
    logic              name_full;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] lower_b;

    // A byte may enter whenever the result register is free this cycle.
    assign byte_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;
    assign b             = byte_in.data_byte;

    // Only A-Z are folded to lower case.
    assign lower_b = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
                   ? b - CHAR_UPPER_A + CHAR_LOWER_A : b;

    // One more character would reach the name limit.
    assign name_full = ({1'b0, chars_reg} + POS_W'(1)) >= NAME_LIMIT;

    // Per-byte decode and state update.
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        label_next    = label_reg;
        chars_next    = chars_reg;
        txid_next     = txid_reg;
        cnt_hi_next   = cnt_hi_reg;
        type_next     = type_reg;
        class_hi_next = class_hi_reg;
        res_load      = 1'b0;
        bad           = 1'b0;
        clear         = 1'b0;
        kind_next     = kind_reg;
        char_next     = char_reg;
        otxid_next    = otxid_reg;
        otype_next    = otype_reg;
        oclass_next   = oclass_reg;
        oend_next     = oend_reg;
        olen_next     = olen_reg;

        if (accept)
        begin
            if (phase_reg == PH_IGNORE)
            begin
                clear = byte_in.last_byte;
            end
            else
            begin
                if (pos_reg != POS_MAX)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                kind_next   = KIND_CHAR;
                char_next   = '0;
                otxid_next  = '0;
                otype_next  = '0;
                oclass_next = '0;
                oend_next   = '0;
                olen_next   = '0;

                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (pos_reg == POS_TXID_HI)
                        begin
                            txid_next = {b, txid_reg[BYTE_W-1:0]};
                        end
                        else if (pos_reg == POS_TXID_LO)
                        begin
                            txid_next = {txid_reg[ID_W-1:BYTE_W], b};
                        end
                        else if (pos_reg == POS_QDCNT_HI)
                        begin
                            cnt_hi_next = (b != '0);
                        end
                        else if (pos_reg == POS_QDCNT_LO && !cnt_hi_reg && b == '0)
                        begin
                            bad = 1'b1;
                        end
                        if (pos_reg >= POS_HDR_LAST)
                        begin
                            phase_next = PH_NAME;
                        end
                    end
                    PH_NAME:
                    begin
                        if (label_reg == '0)
                        begin
                            if (b == '0)
                            begin
                                phase_next = PH_TYPE_HI;
                            end
                            else if ((b & LABEL_FLAG_MASK) != '0)
                            begin
                                bad = 1'b1;
                            end
                            else
                            begin
                                // A new label after the first starts with a dot.
                                if (chars_reg != '0)
                                begin
                                    if (name_full)
                                    begin
                                        bad = 1'b1;
                                    end
                                    else
                                    begin
                                        res_load   = 1'b1;
                                        char_next  = CHAR_DOT;
                                        chars_next = chars_reg + NAME_LEN_W'(1);
                                    end
                                end
                                label_next = b[LABEL_W-1:0];
                            end
                        end
                        else if (name_full)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            res_load   = 1'b1;
                            char_next  = lower_b;
                            chars_next = chars_reg + NAME_LEN_W'(1);
                            label_next = label_reg - LABEL_W'(1);
                        end
                    end
                    PH_TYPE_HI:
                    begin
                        type_next  = {b, type_reg[BYTE_W-1:0]};
                        phase_next = PH_TYPE_LO;
                    end
                    PH_TYPE_LO:
                    begin
                        type_next  = {type_reg[ID_W-1:BYTE_W], b};
                        phase_next = PH_CLASS_HI;
                    end
                    PH_CLASS_HI:
                    begin
                        class_hi_next = b;
                        phase_next    = PH_CLASS_LO;
                    end
                    default:
                    begin
                        // Final qclass byte: the question is complete.
                        res_load    = 1'b1;
                        kind_next   = KIND_DONE;
                        otxid_next  = txid_reg;
                        otype_next  = type_reg;
                        oclass_next = {class_hi_reg, b};
                        oend_next   = pos_reg + POS_W'(1);
                        olen_next   = chars_reg;
                        phase_next  = PH_IGNORE;
                        clear       = byte_in.last_byte;
                    end
                endcase

                // An early end or an error replaces any character word.
                if (phase_reg != PH_CLASS_LO)
                begin
                    if (byte_in.last_byte)
                    begin
                        bad = 1'b1;
                    end
                    if (bad)
                    begin
                        res_load  = 1'b1;
                        kind_next = KIND_BAD;
                        char_next = '0;
                        if (byte_in.last_byte)
                        begin
                            clear = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IGNORE;
                        end
                    end
                end
            end

            if (clear)
            begin
                phase_next = PH_HEADER;
                pos_next   = '0;
                label_next = '0;
                chars_next = '0;
            end
        end

        out_valid_next = res_load || (out_valid_reg && !result_out.ready);
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            label_reg     <= '0;
            chars_reg     <= '0;
            txid_reg      <= '0;
            cnt_hi_reg    <= 1'b0;
            type_reg      <= '0;
            class_hi_reg  <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_CHAR;
            char_reg      <= '0;
            otxid_reg     <= '0;
            otype_reg     <= '0;
            oclass_reg    <= '0;
            oend_reg      <= '0;
            olen_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            label_reg     <= label_next;
            chars_reg     <= chars_next;
            txid_reg      <= txid_next;
            cnt_hi_reg    <= cnt_hi_next;
            type_reg      <= type_next;
            class_hi_reg  <= class_hi_next;
            out_valid_reg <= out_valid_next;
            if (res_load)
            begin
                kind_reg   <= kind_next;
                char_reg   <= char_next;
                otxid_reg  <= otxid_next;
                otype_reg  <= otype_next;
                oclass_reg <= oclass_next;
                oend_reg   <= oend_next;
                olen_reg   <= olen_next;
            end
        end
    end

    // Result channel.
    assign result_out.valid       = out_valid_reg;
    assign result_out.kind        = kind_reg;
    assign result_out.name_char   = char_reg;
    assign result_out.txid        = otxid_reg;
    assign result_out.query_type  = otype_reg;
    assign result_out.query_class = oclass_reg;
    assign result_out.end_offset  = oend_reg;
    assign result_out.name_length = olen_reg;

`ifndef SYNTHESIS
    // The name never grows to the limit.
    a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, chars_reg} < NAME_LIMIT))
        else $error("name length reached the limit");

    // In the header phase no name state is left over from an earlier packet.
    a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (chars_reg == '0 && label_reg == '0))
        else $error("stale name state in header phase");

    // Dropped bytes without the last-byte mark keep the parser idle.
    a_ignore_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_IGNORE && !byte_in.last_byte)
        |=> (phase_reg == PH_IGNORE && !$past(res_load)))
        else $error("parser left the drop phase without a last byte");

    // A done word always covers the header, terminator, qtype and qclass.
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_DONE) |-> (oend_reg >= POS_W'(17)))
        else $error("done word with a short question end");
`endif

endmodule
